[rtl/core/nsp_pkg.sv]
// nsp_pkg: widths, action codes and shared types of the nearest segment picker
// no dependencies
`timescale 1ns / 1ps

package nsp_pkg;

	localparam int COORD_WIDTH  = 28;
	localparam int DIFF_WIDTH   = COORD_WIDTH + 1;
	localparam int DIST_WIDTH   = 58;
	localparam int TOL_WIDTH    = 28;
	localparam int TOLSQ_WIDTH  = 2 * TOL_WIDTH;
	localparam int SLOT_WIDTH   = 6;
	localparam int ACTION_WIDTH = 2;

	localparam logic [ACTION_WIDTH-1:0] ACT_WRITE = 2'd0;
	localparam logic [ACTION_WIDTH-1:0] ACT_QUERY = 2'd1;
	localparam logic [ACTION_WIDTH-1:0] ACT_CLEAR = 2'd2;

	localparam logic [TOL_WIDTH-1:0]   TOL_RESET    = 28'd128000;
	localparam logic [TOLSQ_WIDTH-1:0] TOL_SQ_RESET = 56'd16384000000;

	typedef logic signed [COORD_WIDTH-1:0] coord_t;

	typedef struct packed {
		coord_t ax;
		coord_t ay;
		coord_t bx;
		coord_t by;
	} seg_t;

	typedef struct packed {
		logic                  done;
		logic [DIST_WIDTH-1:0] dist_sq;
	} dist_res_t;

endpackage

[rtl/core/nsp_if.sv]
// nsp_if: request, result and configuration channels of the picker
// depends on nsp_pkg
`timescale 1ns / 1ps

interface nsp_req_if;
	logic                             valid;
	logic                             ready;
	logic [nsp_pkg::ACTION_WIDTH-1:0] action;
	logic [nsp_pkg::SLOT_WIDTH-1:0]   slot;
	logic                             eligible;
	nsp_pkg::coord_t                  start_x;
	nsp_pkg::coord_t                  start_y;
	nsp_pkg::coord_t                  end_x;
	nsp_pkg::coord_t                  end_y;
	nsp_pkg::coord_t                  query_x;
	nsp_pkg::coord_t                  query_y;

	modport source (output valid, action, slot, eligible, start_x, start_y, end_x, end_y,
		query_x, query_y, input ready);
	modport sink (input valid, action, slot, eligible, start_x, start_y, end_x, end_y,
		query_x, query_y, output ready);
endinterface

interface nsp_rsp_if;
	logic                           valid;
	logic                           ready;
	logic                           found;
	logic [nsp_pkg::SLOT_WIDTH-1:0] best_slot;
	logic [nsp_pkg::DIST_WIDTH-1:0] best_dist_sq;

	modport source (output valid, found, best_slot, best_dist_sq, input ready);
	modport sink (input valid, found, best_slot, best_dist_sq, output ready);
endinterface

interface nsp_cfg_if;
	logic                          valid;
	logic                          ready;
	logic [nsp_pkg::TOL_WIDTH-1:0] data;

	modport source (output valid, data, input ready);
	modport sink (input valid, data, output ready);
endinterface

[rtl/core/nsp_seg_table.sv]
// nsp_seg_table: segment memory with registered read and per-slot eligible flags
// depends on nsp_pkg
`timescale 1ns / 1ps

module nsp_seg_table #(
	parameter int MAX_SEGMENTS = 64,
	parameter int AW = $clog2(MAX_SEGMENTS)
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          wr_en,
	input  logic [AW-1:0] wr_addr,
	input  logic          wr_flag,
	input  nsp_pkg::seg_t wr_data,
	input  logic          clr,
	input  logic [AW-1:0] scan_addr,
	output logic          scan_flag,
	input  logic          rd_en,
	output nsp_pkg::seg_t rd_data
);

	nsp_pkg::seg_t mem [MAX_SEGMENTS];
	logic [MAX_SEGMENTS-1:0] flag_q;
	nsp_pkg::seg_t rd_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_q <= mem[scan_addr];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			flag_q <= '0;
		end else if (clr) begin
			flag_q <= '0;
		end else if (wr_en) begin
			flag_q[wr_addr] <= wr_flag;
		end
	end

	assign scan_flag = flag_q[scan_addr];
	assign rd_data   = rd_q;

endmodule

[rtl/core/nsp_dist_unit.sv]
// nsp_dist_unit: point to segment squared distance on one shared multiplier
// and a restoring divider, stepped by a small sequencer; depends on nsp_pkg
`timescale 1ns / 1ps

module nsp_dist_unit (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	input  nsp_pkg::coord_t    px,
	input  nsp_pkg::coord_t    py,
	input  nsp_pkg::seg_t      seg,
	output nsp_pkg::dist_res_t res
);

	localparam int DW = nsp_pkg::DIFF_WIDTH;
	localparam int QW = nsp_pkg::DIST_WIDTH;
	localparam int NW = 2 * QW;
	localparam int HW = DW;
	localparam int CW = $clog2(QW);

	localparam logic [4:0] D_IDLE   = 5'd0;
	localparam logic [4:0] D_APX2   = 5'd1;
	localparam logic [4:0] D_APY2   = 5'd2;
	localparam logic [4:0] D_ABX2   = 5'd3;
	localparam logic [4:0] D_ABY2   = 5'd4;
	localparam logic [4:0] D_DOTX   = 5'd5;
	localparam logic [4:0] D_DOTY   = 5'd6;
	localparam logic [4:0] D_DECIDE = 5'd7;
	localparam logic [4:0] D_BPX2   = 5'd8;
	localparam logic [4:0] D_BPY2   = 5'd9;
	localparam logic [4:0] D_CRX    = 5'd10;
	localparam logic [4:0] D_CRY    = 5'd11;
	localparam logic [4:0] D_SPLIT  = 5'd12;
	localparam logic [4:0] D_HH     = 5'd13;
	localparam logic [4:0] D_HL     = 5'd14;
	localparam logic [4:0] D_LL     = 5'd15;
	localparam logic [4:0] D_DIVI   = 5'd16;
	localparam logic [4:0] D_DIV    = 5'd17;
	localparam logic [4:0] D_DONE   = 5'd18;

	logic [4:0] state_q;
	logic signed [DW-1:0] apx_q, apy_q, abx_q, aby_q, bpx_q, bpy_q;
	logic signed [63:0] acc_q;
	logic [QW-1:0] ap2_q, ab2_q, res_q;
	logic [HW-1:0] hi_q, lo_q;
	logic [NW-1:0] num_q;
	logic [QW:0]   rem_q;
	logic [QW-1:0] nq_q;
	logic [CW-1:0] cnt_q;

	logic signed [31:0] ma, mb;
	logic signed [63:0] prod;
	logic signed [63:0] sum;
	logic [63:0] cmag;
	logic [QW:0] rem_sh, rem_nx;
	logic ge;
	logic [QW-1:0] nq_nx;

	// one shared multiplier, operands picked by step
	always_comb begin
		ma = '0;
		mb = '0;
		case (state_q)
			D_APX2: begin ma = 32'(apx_q); mb = 32'(apx_q); end
			D_APY2: begin ma = 32'(apy_q); mb = 32'(apy_q); end
			D_ABX2: begin ma = 32'(abx_q); mb = 32'(abx_q); end
			D_ABY2: begin ma = 32'(aby_q); mb = 32'(aby_q); end
			D_DOTX: begin ma = 32'(apx_q); mb = 32'(abx_q); end
			D_DOTY: begin ma = 32'(apy_q); mb = 32'(aby_q); end
			D_BPX2: begin ma = 32'(bpx_q); mb = 32'(bpx_q); end
			D_BPY2: begin ma = 32'(bpy_q); mb = 32'(bpy_q); end
			D_CRX:  begin ma = 32'(apx_q); mb = 32'(aby_q); end
			D_CRY:  begin ma = 32'(apy_q); mb = 32'(abx_q); end
			D_HH:   begin ma = $signed({3'b0, hi_q}); mb = $signed({3'b0, hi_q}); end
			D_HL:   begin ma = $signed({3'b0, hi_q}); mb = $signed({3'b0, lo_q}); end
			D_LL:   begin ma = $signed({3'b0, lo_q}); mb = $signed({3'b0, lo_q}); end
			default: begin ma = '0; mb = '0; end
		endcase
	end

	assign prod = ma * mb;
	assign sum  = (state_q == D_CRY) ? acc_q - prod : acc_q + prod;
	assign cmag = acc_q[63] ? 64'(-acc_q) : 64'(acc_q);

	assign rem_sh = {rem_q[QW-1:0], nq_q[QW-1]};
	assign ge     = rem_sh >= {1'b0, ab2_q};
	assign rem_nx = ge ? rem_sh - {1'b0, ab2_q} : rem_sh;
	assign nq_nx  = {nq_q[QW-2:0], ge};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= D_IDLE;
		end else begin
			case (state_q)
				D_IDLE:   if (start) state_q <= D_APX2;
				D_APX2:   state_q <= D_APY2;
				D_APY2:   state_q <= D_ABX2;
				D_ABX2:   state_q <= D_ABY2;
				D_ABY2:   state_q <= D_DOTX;
				D_DOTX:   state_q <= D_DOTY;
				D_DOTY:   state_q <= D_DECIDE;
				D_DECIDE: begin
					if (ab2_q == '0 || acc_q <= 0) begin
						state_q <= D_DONE;
					end else if (acc_q >= $signed({6'b0, ab2_q})) begin
						state_q <= D_BPX2;
					end else begin
						state_q <= D_CRX;
					end
				end
				D_BPX2:   state_q <= D_BPY2;
				D_BPY2:   state_q <= D_DONE;
				D_CRX:    state_q <= D_CRY;
				D_CRY:    state_q <= D_SPLIT;
				D_SPLIT:  state_q <= D_HH;
				D_HH:     state_q <= D_HL;
				D_HL:     state_q <= D_LL;
				D_LL:     state_q <= D_DIVI;
				D_DIVI:   state_q <= D_DIV;
				D_DIV:    if (cnt_q == CW'(QW - 1)) state_q <= D_DONE;
				D_DONE:   state_q <= D_IDLE;
				default:  state_q <= D_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			D_IDLE: begin
				apx_q <= DW'(px) - DW'(seg.ax);
				apy_q <= DW'(py) - DW'(seg.ay);
				abx_q <= DW'(seg.bx) - DW'(seg.ax);
				aby_q <= DW'(seg.by) - DW'(seg.ay);
				bpx_q <= DW'(px) - DW'(seg.bx);
				bpy_q <= DW'(py) - DW'(seg.by);
			end
			D_APX2, D_ABX2, D_DOTX, D_BPX2, D_CRX: acc_q <= prod;
			D_APY2: ap2_q <= QW'(sum);
			D_ABY2: ab2_q <= QW'(sum);
			D_DOTY, D_CRY: acc_q <= sum;
			D_DECIDE: res_q <= ap2_q;
			D_BPY2: res_q <= QW'(sum);
			D_SPLIT: begin
				hi_q <= cmag[2*HW-1:HW];
				lo_q <= cmag[HW-1:0];
			end
			D_HH: num_q <= NW'(prod) << (2 * HW);
			D_HL: num_q <= num_q + (NW'(prod) << (HW + 1));
			D_LL: num_q <= num_q + NW'(prod);
			D_DIVI: begin
				rem_q <= {1'b0, num_q[NW-1:QW]};
				nq_q  <= num_q[QW-1:0];
				cnt_q <= '0;
			end
			D_DIV: begin
				rem_q <= rem_nx;
				nq_q  <= nq_nx;
				cnt_q <= cnt_q + 1'b1;
				res_q <= nq_nx;
			end
			default: ;
		endcase
	end

	assign res.done    = state_q == D_DONE;
	assign res.dist_sq = res_q;

endmodule

[rtl/core/nearest_segment_picker.sv]
// nearest_segment_picker: top level, scan sequencer, best tracking, result register
// depends on nsp_pkg, nsp_if, nsp_seg_table, nsp_dist_unit
`timescale 1ns / 1ps

// Usage:
//   req carries one item per valid/ready handshake: a write (store a segment and
//   its eligible flag in a slot), a clear (drop all flags) or a query point.
//   rsp returns one item per query: found, best_slot and best_dist_sq.
//   cfg writes pick_tolerance and is always ready; the user must write it only
//   while idle, and the block itself does not enforce this. A write or clear is
//   taken while idle. A query keeps req busy while the scan visits every slot:
//   an unflagged slot is skipped, a flagged one is read and run through the
//   distance sequencer on its one multiplier, whose path is shortest when the
//   projection falls before the start or the segment has zero length, longer
//   when it falls past the end and longest when it is interior, where the
//   restoring divider gives one quotient bit per cycle. The result shows as req
//   turns ready. req is not ready while a query runs.
// Reset and stalls:
//   reset clears all flags and sets the tolerance to 500 m; stored segments are
//   undefined until written. The result sits in an output register; a stalled
//   rsp holds it, and a following write or clear is still taken meanwhile.

module nearest_segment_picker #(
	parameter int MAX_SEGMENTS = 64
) (
	input  logic      clk,
	input  logic      arst_n,
	nsp_req_if.sink   req,
	nsp_rsp_if.source rsp,
	nsp_cfg_if.sink   cfg
);

	localparam int AW = $clog2(MAX_SEGMENTS);
	localparam int QW = nsp_pkg::DIST_WIDTH;

	localparam logic [2:0] T_IDLE = 3'd0;
	localparam logic [2:0] T_SCAN = 3'd1;
	localparam logic [2:0] T_READ = 3'd2;
	localparam logic [2:0] T_WAIT = 3'd3;
	localparam logic [2:0] T_FIN  = 3'd4;

	logic [2:0] state_q;
	logic [AW-1:0] idx_q, best_idx_q;
	logic have_q;
	logic [QW-1:0] best_q;
	nsp_pkg::coord_t px_q, py_q;
	logic [nsp_pkg::TOL_WIDTH-1:0] tol_q;
	logic [nsp_pkg::TOLSQ_WIDTH-1:0] tol_sq_q;

	logic out_valid_q, out_found_q;
	logic [nsp_pkg::SLOT_WIDTH-1:0] out_slot_q;
	logic [QW-1:0] out_dist_q;

	logic acc_in, wr_en, clr, scan_flag, rd_en, last, better, fin_load, hit;
	nsp_pkg::seg_t wr_data, rd_data;
	nsp_pkg::dist_res_t dres;

	assign req.ready = state_q == T_IDLE;
	assign acc_in    = req.valid && req.ready;
	assign wr_en     = acc_in && req.action == nsp_pkg::ACT_WRITE
		&& 32'(req.slot) < MAX_SEGMENTS;
	assign clr       = acc_in && req.action == nsp_pkg::ACT_CLEAR;
	assign wr_data   = '{ax: req.start_x, ay: req.start_y, bx: req.end_x, by: req.end_y};
	assign rd_en     = state_q == T_SCAN && scan_flag;
	assign last      = idx_q == AW'(MAX_SEGMENTS - 1);
	assign better    = !have_q || dres.dist_sq < best_q;
	assign fin_load  = state_q == T_FIN && (!out_valid_q || rsp.ready);
	assign hit       = have_q && best_q <= QW'(tol_sq_q);

	nsp_seg_table #(.MAX_SEGMENTS(MAX_SEGMENTS), .AW(AW)) u_table (
		.clk       (clk),
		.arst_n    (arst_n),
		.wr_en     (wr_en),
		.wr_addr   (AW'(req.slot)),
		.wr_flag   (req.eligible),
		.wr_data   (wr_data),
		.clr       (clr),
		.scan_addr (idx_q),
		.scan_flag (scan_flag),
		.rd_en     (rd_en),
		.rd_data   (rd_data)
	);

	nsp_dist_unit u_dist (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (state_q == T_READ),
		.px     (px_q),
		.py     (py_q),
		.seg    (rd_data),
		.res    (dres)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= T_IDLE;
			idx_q   <= '0;
			have_q  <= 1'b0;
		end else begin
			case (state_q)
				T_IDLE: begin
					if (acc_in && req.action == nsp_pkg::ACT_QUERY) begin
						idx_q   <= '0;
						have_q  <= 1'b0;
						state_q <= T_SCAN;
					end
				end
				T_SCAN: begin
					if (scan_flag) begin
						state_q <= T_READ;
					end else if (last) begin
						state_q <= T_FIN;
					end else begin
						idx_q <= idx_q + 1'b1;
					end
				end
				T_READ: state_q <= T_WAIT;
				T_WAIT: begin
					if (dres.done) begin
						if (better) have_q <= 1'b1;
						if (last) begin
							state_q <= T_FIN;
						end else begin
							idx_q   <= idx_q + 1'b1;
							state_q <= T_SCAN;
						end
					end
				end
				T_FIN: if (fin_load) state_q <= T_IDLE;
				default: state_q <= T_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (acc_in) begin
			px_q <= req.query_x;
			py_q <= req.query_y;
		end
		if (state_q == T_WAIT && dres.done && better) begin
			best_q     <= dres.dist_sq;
			best_idx_q <= idx_q;
		end
		if (fin_load) begin
			out_found_q <= hit;
			out_slot_q  <= hit ? nsp_pkg::SLOT_WIDTH'(best_idx_q) : '0;
			out_dist_q  <= hit ? best_q : '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			tol_q       <= nsp_pkg::TOL_RESET;
			tol_sq_q    <= nsp_pkg::TOL_SQ_RESET;
		end else begin
			if (fin_load) begin
				out_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				out_valid_q <= 1'b0;
			end
			if (cfg.valid) tol_q <= cfg.data;
			tol_sq_q <= tol_q * tol_q;
		end
	end

	assign cfg.ready        = 1'b1;
	assign rsp.valid        = out_valid_q;
	assign rsp.found        = out_found_q;
	assign rsp.best_slot    = out_slot_q;
	assign rsp.best_dist_sq = out_dist_q;

	// a found result never lies beyond the tolerance
	a_found_in_tol: assert property (@(posedge clk) disable iff (!arst_n)
		rsp.valid && rsp.found |-> rsp.best_dist_sq <= QW'(tol_sq_q))
		else $error("found result beyond tolerance");

	// a miss reports zero slot and distance
	a_miss_zero: assert property (@(posedge clk) disable iff (!arst_n)
		rsp.valid && !rsp.found |-> rsp.best_slot == '0 && rsp.best_dist_sq == '0)
		else $error("miss with nonzero payload");

	// the distance unit only finishes while the scan waits for it
	a_done_when_waiting: assert property (@(posedge clk) disable iff (!arst_n)
		dres.done |-> state_q == T_WAIT)
		else $error("distance done outside wait");

	// a query item leaves the block busy on the next cycle
	a_query_busy: assert property (@(posedge clk) disable iff (!arst_n)
		acc_in && req.action == nsp_pkg::ACT_QUERY |=> !req.ready)
		else $error("ready right after query");

endmodule

[tb/nearest_segment_picker_tb.sv]
// nearest_segment_picker_tb: directed and random test of the segment picker
// a scoreboard class predicts each pick exactly; depends on nsp_pkg, nsp_if and the rtl
`timescale 1ns / 1ps

module nearest_segment_picker_tb;

	typedef struct {
		logic [nsp_pkg::ACTION_WIDTH-1:0] action;
		logic [nsp_pkg::SLOT_WIDTH-1:0]   slot;
		logic                             eligible;
		nsp_pkg::coord_t                  sx, sy, ex, ey, qx, qy;
	} seg_item_t;

	typedef struct {
		logic                           found;
		logic [nsp_pkg::SLOT_WIDTH-1:0] slot;
		logic [nsp_pkg::DIST_WIDTH-1:0] dist_sq;
	} pick_t;

	localparam logic [nsp_pkg::ACTION_WIDTH-1:0] ACT_UNUSED = 2'd3;
	localparam longint unsigned DIST_CAP = 64'h03FF_FFFF_FFFF_FFFF;
	localparam int WATCHDOG_LIMIT = 60000;
	localparam int HOLD_CYCLES = 3000;
	localparam nsp_pkg::coord_t CMIN = nsp_pkg::coord_t'(-134217728);
	localparam nsp_pkg::coord_t CMAX = 28'sd134217727;

	class seg_scoreboard;
		longint sx[64], sy[64], ex[64], ey[64];
		bit flag[64];
		longint unsigned tol = nsp_pkg::TOL_RESET;
		pick_t picks_due[$];
		int errors = 0;

		function longint unsigned sat(longint unsigned v);
			return (v > DIST_CAP) ? DIST_CAP : v;
		endfunction

		function longint unsigned seg_dist(longint px, longint py, int s);
			longint apx, apy, abx, aby, ab2, ap2, dot, cr;
			longint unsigned mag;
			logic [127:0] c2, q;
			apx = px - sx[s]; apy = py - sy[s];
			abx = ex[s] - sx[s]; aby = ey[s] - sy[s];
			ab2 = abx * abx + aby * aby;
			ap2 = apx * apx + apy * apy;
			if (ab2 == 0)
				return sat(ap2);
			dot = apx * abx + apy * aby;
			if (dot <= 0)
				return sat(ap2);
			if (dot >= ab2)
				return sat((px - ex[s]) * (px - ex[s]) + (py - ey[s]) * (py - ey[s]));
			// interior: |AP|^2|AB|^2 - dot^2 equals cross^2
			cr = apx * aby - apy * abx;
			mag = (cr < 0) ? -cr : cr;
			c2 = {64'd0, mag} * {64'd0, mag};
			q = c2 / {64'd0, ab2};
			return (q > DIST_CAP) ? DIST_CAP : q[63:0];
		endfunction

		function void note_item(seg_item_t it);
			pick_t p;
			longint unsigned best, d;
			bit have;
			case (it.action)
				nsp_pkg::ACT_WRITE: begin
					flag[it.slot] = it.eligible;
					sx[it.slot] = it.sx; sy[it.slot] = it.sy;
					ex[it.slot] = it.ex; ey[it.slot] = it.ey;
				end
				nsp_pkg::ACT_CLEAR: begin
					foreach (flag[i]) flag[i] = 0;
				end
				nsp_pkg::ACT_QUERY: begin
					have = 0; best = 0; p.slot = 0;
					for (int s = 0; s < 64; s++) begin
						if (flag[s]) begin
							d = seg_dist(it.qx, it.qy, s);
							if (!have || d < best) begin
								have = 1; best = d; p.slot = nsp_pkg::SLOT_WIDTH'(s);
							end
						end
					end
					if (have && best <= tol * tol) begin
						p.found = 1; p.dist_sq = best;
					end else begin
						p.found = 0; p.slot = 0; p.dist_sq = 0;
					end
					picks_due.push_back(p);
				end
				default: ;
			endcase
		endfunction

		function void check_pick(logic f, logic [nsp_pkg::SLOT_WIDTH-1:0] s,
			logic [nsp_pkg::DIST_WIDTH-1:0] d);
			pick_t e;
			if (picks_due.size() == 0) begin
				$error("unexpected result item found=%0d slot=%0d dist=%0d", f, s, d);
				errors++;
				return;
			end
			e = picks_due.pop_front();
			if (f !== e.found) begin
				$error("found: expected %0d actual %0d", e.found, f); errors++;
			end
			if (s !== e.slot) begin
				$error("best_slot: expected %0d actual %0d", e.slot, s); errors++;
			end
			if (d !== e.dist_sq) begin
				$error("best_dist_sq: expected %0d actual %0d", e.dist_sq, d); errors++;
			end
		endfunction
	endclass

	logic clk, arst_n;
	nsp_req_if req();
	nsp_rsp_if rsp();
	nsp_cfg_if cfg();

	nearest_segment_picker u_top (.clk(clk), .arst_n(arst_n), .req(req), .rsp(rsp), .cfg(cfg));

	seg_scoreboard sb = new();
	int send_idle_pct = 0;
	int recv_stall_pct = 0;
	bit start_hold = 0;

	initial begin
		clk = 0;
		forever #2 clk = ~clk;
	end

	// receiver with random stalls and one long hold-off
	initial begin
		int hold_cnt;
		bit held;
		hold_cnt = 0;
		held = 0;
		rsp.ready = 0;
		forever begin
			@(posedge clk);
			if (rsp.valid && rsp.ready)
				sb.check_pick(rsp.found, rsp.best_slot, rsp.best_dist_sq);
			if (start_hold && !held) begin
				held = 1;
				hold_cnt = HOLD_CYCLES;
			end
			if (hold_cnt > 0) begin
				hold_cnt--;
				rsp.ready <= 0;
			end else begin
				rsp.ready <= ($urandom_range(99) >= recv_stall_pct);
			end
		end
	end

	// watchdog on cycles with no item moving
	initial begin
		int quiet;
		quiet = 0;
		forever begin
			@(posedge clk);
			if ((req.valid && req.ready) || (rsp.valid && rsp.ready) || (cfg.valid && cfg.ready))
				quiet = 0;
			else
				quiet++;
			if (quiet >= WATCHDOG_LIMIT) begin
				$display("TEST FAILED");
				$finish;
			end
		end
	end

	task automatic send_item(seg_item_t it);
		while ($urandom_range(99) < send_idle_pct) begin
			req.valid <= 0;
			@(posedge clk);
		end
		req.valid <= 1;
		req.action <= it.action; req.slot <= it.slot; req.eligible <= it.eligible;
		req.start_x <= it.sx; req.start_y <= it.sy; req.end_x <= it.ex; req.end_y <= it.ey;
		req.query_x <= it.qx; req.query_y <= it.qy;
		do @(posedge clk); while (!req.ready);
		sb.note_item(it);
	endtask

	task automatic drain();
		req.valid <= 0;
		@(posedge clk);
		while (sb.picks_due.size() != 0) @(posedge clk);
		// writes and clears leave no result, let the last one settle
		repeat (100) @(posedge clk);
	endtask

	task automatic set_tolerance(logic [nsp_pkg::TOL_WIDTH-1:0] v);
		drain();
		cfg.valid <= 1;
		cfg.data <= v;
		do @(posedge clk); while (!cfg.ready);
		cfg.valid <= 0;
		sb.tol = v;
	endtask

	function automatic nsp_pkg::coord_t rand_coord();
		case ($urandom_range(7))
			0: return nsp_pkg::coord_t'($urandom);
			1: return $urandom_range(1) ? CMAX : CMIN;
			default: return nsp_pkg::coord_t'(int'($urandom_range(262143)) - 131072);
		endcase
	endfunction

	function automatic seg_item_t mk(logic [nsp_pkg::ACTION_WIDTH-1:0] a, int s, bit el,
		nsp_pkg::coord_t ax, nsp_pkg::coord_t ay, nsp_pkg::coord_t bx, nsp_pkg::coord_t by,
		nsp_pkg::coord_t px, nsp_pkg::coord_t py);
		seg_item_t it;
		it.action = a; it.slot = nsp_pkg::SLOT_WIDTH'(s); it.eligible = el;
		it.sx = ax; it.sy = ay; it.ex = bx; it.ey = by; it.qx = px; it.qy = py;
		return it;
	endfunction

	function automatic seg_item_t rand_item();
		seg_item_t it;
		int r;
		it = mk(nsp_pkg::ACT_WRITE, $urandom_range(63), $urandom_range(99) < 80, rand_coord(),
			rand_coord(), rand_coord(), rand_coord(), rand_coord(), rand_coord());
		r = $urandom_range(99);
		if (r < 55) it.action = nsp_pkg::ACT_WRITE;
		else if (r < 85) it.action = nsp_pkg::ACT_QUERY;
		else if (r < 95) it.action = nsp_pkg::ACT_CLEAR;
		else it.action = ACT_UNUSED;
		// zero-length segments now and then
		if ($urandom_range(9) == 0) begin
			it.ex = it.sx; it.ey = it.sy;
		end
		return it;
	endfunction

	initial begin
		seg_item_t dir[$];
		req.valid = 0; req.action = nsp_pkg::ACT_WRITE; req.slot = 0; req.eligible = 0;
		req.start_x = 0; req.start_y = 0; req.end_x = 0; req.end_y = 0;
		req.query_x = 0; req.query_y = 0;
		cfg.valid = 0; cfg.data = 0;
		arst_n = 0;
		repeat (6) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);

		dir.push_back(mk(nsp_pkg::ACT_QUERY, 0, 0, 0, 0, 0, 0, 0, 0));
		dir.push_back(mk(nsp_pkg::ACT_WRITE, 5, 1, 0, 0, 25600, 0, 0, 0));
		dir.push_back(mk(nsp_pkg::ACT_WRITE, 2, 1, 0, 0, 25600, 0, 0, 0));
		dir.push_back(mk(nsp_pkg::ACT_QUERY, 0, 0, 0, 0, 0, 0, 12800, 256));
		dir.push_back(mk(nsp_pkg::ACT_QUERY, 0, 0, 0, 0, 0, 0, -1000, 0));
		dir.push_back(mk(nsp_pkg::ACT_QUERY, 0, 0, 0, 0, 0, 0, 30000, 100));
		dir.push_back(mk(nsp_pkg::ACT_WRITE, 63, 1, 1000, 1000, 1000, 1000, 0, 0));
		dir.push_back(mk(nsp_pkg::ACT_QUERY, 0, 0, 0, 0, 0, 0, 1000, 1000));
		dir.push_back(mk(nsp_pkg::ACT_WRITE, 63, 0, 1000, 1000, 1000, 1000, 0, 0));
		dir.push_back(mk(nsp_pkg::ACT_QUERY, 0, 0, 0, 0, 0, 0, 1000, 1000));
		dir.push_back(mk(ACT_UNUSED, 7, 1, CMAX, CMAX, CMIN, CMIN, CMAX, CMIN));
		dir.push_back(mk(nsp_pkg::ACT_CLEAR, 0, 0, 0, 0, 0, 0, 0, 0));
		dir.push_back(mk(nsp_pkg::ACT_QUERY, 0, 0, 0, 0, 0, 0, 12800, 0));
		dir.push_back(mk(nsp_pkg::ACT_WRITE, 10, 1, CMIN, CMIN, CMAX, CMAX, 0, 0));
		dir.push_back(mk(nsp_pkg::ACT_QUERY, 0, 0, 0, 0, 0, 0, CMAX, CMIN));
		dir.push_back(mk(nsp_pkg::ACT_WRITE, 11, 1, CMIN, CMIN, CMIN, CMIN, 0, 0));
		dir.push_back(mk(nsp_pkg::ACT_WRITE, 10, 0, CMIN, CMIN, CMAX, CMAX, 0, 0));
		// far corner: well beyond any tolerance
		dir.push_back(mk(nsp_pkg::ACT_QUERY, 0, 0, 0, 0, 0, 0, CMAX, CMAX));
		dir.push_back(mk(nsp_pkg::ACT_WRITE, 1, 1, CMAX, CMIN, CMIN, CMAX, 0, 0));
		dir.push_back(mk(nsp_pkg::ACT_QUERY, 63, 1, CMAX, CMAX, CMAX, CMAX, CMIN, CMIN));
		dir.push_back(mk(nsp_pkg::ACT_CLEAR, 63, 1, CMIN, CMIN, CMIN, CMIN, CMAX, CMAX));
		foreach (dir[i]) send_item(dir[i]);

		for (int ph = 0; ph < 5; ph++) begin
			case (ph)
				0: set_tolerance(nsp_pkg::TOL_RESET);
				1: set_tolerance('0);
				2: set_tolerance('1);
				3: set_tolerance(nsp_pkg::TOL_WIDTH'($urandom_range(1000000)));
				default: set_tolerance(nsp_pkg::TOL_WIDTH'(200000));
			endcase
			send_idle_pct  = (ph == 1) ? 74 : (ph == 3) ? 26 : 0;
			recv_stall_pct = (ph == 2) ? 74 : (ph == 3) ? 26 : 0;
			if (ph == 4) start_hold = 1;
			for (int n = 0; n < 260; n++) send_item(rand_item());
		end

		drain();
		if (sb.errors == 0 && sb.picks_due.size() == 0) begin
			$display("TEST PASSED");
		end else begin
			$display("TEST FAILED");
		end
		$finish;
	end

endmodule
